FILE: sv/complex_arithmetic_unit_assert.svh
// assertion macros used by the queue of the complex arithmetic unit rtl
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// condition must never hold at a clock edge outside reset
`define CAU_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define CAU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/cau_pkg.sv
// types, constants and datapath functions of the complex arithmetic unit
package cau_pkg;

   localparam int IN_WIDTH    = 32;
   localparam int DATA_WIDTH  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 1;
   localparam int MAG_WIDTH   = PROD_WIDTH;
   localparam int QUO_BITS    = DATA_WIDTH + 1;
   localparam int HEAD_SHIFT  = QUO_BITS - FRAC_BITS;
   localparam int REM_WIDTH   = MAG_WIDTH + 1;
   localparam int ROOT_BITS   = QUO_BITS;
   localparam int SX_WIDTH    = 2 * ROOT_BITS;
   localparam int SREM_WIDTH  = ROOT_BITS + 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_NEG  = 3'd4,
      OP_EQU  = 3'd5,
      OP_MAG  = 3'd6,
      OP_NONE = 3'd7
   } op_type;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   typedef struct packed {
      op_type   op;
      data_type a_re;
      data_type a_im;
      data_type b_re;
      data_type b_im;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      data_type val;
      logic     sat;
   } res_type;

   typedef struct packed {
      op_type                done_op;
      data_type              done_re;
      data_type              done_im;
      logic                  done_eq;
      logic                  done_sat;
      logic                  dz;
      logic                  neg_re;
      logic                  neg_im;
      logic                  ovf_re;
      logic                  ovf_im;
      logic [REM_WIDTH-1:0]  rem_re;
      logic [REM_WIDTH-1:0]  rem_im;
      logic [QUO_BITS-1:0]   nlo_re;
      logic [QUO_BITS-1:0]   nlo_im;
      logic [QUO_BITS-1:0]   q_re;
      logic [QUO_BITS-1:0]   q_im;
      logic [MAG_WIDTH-1:0]  den;
      logic [SREM_WIDTH-1:0] srem;
      logic [ROOT_BITS-1:0]  sroot;
      logic [SX_WIDTH-1:0]   sx;
   } iter_type;

   // clip a sign and magnitude value to the data range
   function automatic res_type sat_sm(input logic neg, input logic [MAG_WIDTH-1:0] mag);
      logic [MAG_WIDTH-1:0] maxpos;
      res_type r;
      maxpos = {{(MAG_WIDTH - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
      r.sat = 1'b0;
      if (!neg) begin
         if (mag > maxpos) begin
            r.sat = 1'b1;
            r.val = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
         end else begin
            r.val = mag[DATA_WIDTH-1:0];
         end
      end else if (mag > maxpos + 1'b1) begin
         r.sat = 1'b1;
         r.val = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
      end else begin
         r.val = -mag[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   // clip a one bit wider two's complement value
   function automatic res_type sat_short(input logic signed [DATA_WIDTH:0] v);
      res_type r;
      r.sat = v[DATA_WIDTH] != v[DATA_WIDTH-1];
      if (r.sat) begin
         r.val = v[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH - 1){1'b0}}}
                               : {1'b0, {(DATA_WIDTH - 1){1'b1}}};
      end else begin
         r.val = v[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   // one quotient bit per divide lane and one root bit
   function automatic iter_type iter_step(input iter_type x);
      iter_type y;
      logic [REM_WIDTH-1:0] dden;
      logic [REM_WIDTH-1:0] dre;
      logic [REM_WIDTH-1:0] dim;
      logic [SREM_WIDTH-1:0] sr;
      logic [SREM_WIDTH-1:0] st;
      y = x;
      dden = {1'b0, x.den};
      dre = {x.rem_re[REM_WIDTH-2:0], x.nlo_re[QUO_BITS-1]};
      dim = {x.rem_im[REM_WIDTH-2:0], x.nlo_im[QUO_BITS-1]};
      y.nlo_re = {x.nlo_re[QUO_BITS-2:0], 1'b0};
      y.nlo_im = {x.nlo_im[QUO_BITS-2:0], 1'b0};
      if (dre >= dden) begin
         y.rem_re = dre - dden;
         y.q_re = {x.q_re[QUO_BITS-2:0], 1'b1};
      end else begin
         y.rem_re = dre;
         y.q_re = {x.q_re[QUO_BITS-2:0], 1'b0};
      end
      if (dim >= dden) begin
         y.rem_im = dim - dden;
         y.q_im = {x.q_im[QUO_BITS-2:0], 1'b1};
      end else begin
         y.rem_im = dim;
         y.q_im = {x.q_im[QUO_BITS-2:0], 1'b0};
      end
      sr = {x.srem[SREM_WIDTH-3:0], x.sx[SX_WIDTH-1 -: 2]};
      st = SREM_WIDTH'({x.sroot, 2'b01});
      y.sx = {x.sx[SX_WIDTH-3:0], 2'b00};
      if (sr >= st) begin
         y.srem = sr - st;
         y.sroot = {x.sroot[ROOT_BITS-2:0], 1'b1};
      end else begin
         y.srem = sr;
         y.sroot = {x.sroot[ROOT_BITS-2:0], 1'b0};
      end
      return y;
   endfunction

endpackage

FILE: sv/cau_front.sv
// front end: takes requests, decodes the action and hands items to the queue
module cau_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0]                  req_action,
   input  logic signed [31:0]          req_a_re,
   input  logic signed [31:0]          req_a_im,
   input  logic signed [31:0]          req_b_re,
   input  logic signed [31:0]          req_b_im,
   input  cau_pkg::queue_status_type   qstat,
   output logic                        push,
   output cau_pkg::item_type           item
);
   import cau_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     ready;
   logic     accept;
   item_type decoded;

   always_comb begin
      decoded.op   = op_type'(req_action);
      decoded.a_re = data_type'(req_a_re[DATA_WIDTH-1:0]);
      decoded.a_im = data_type'(req_a_im[DATA_WIDTH-1:0]);
      decoded.b_re = data_type'(req_b_re[DATA_WIDTH-1:0]);
      decoded.b_im = data_type'(req_b_im[DATA_WIDTH-1:0]);
   end

   assign push   = valid_ff && !qstat.full;
   assign ready  = !valid_ff || push;
   assign busy   = reset || !ready;
   assign accept = start && !busy;
   assign item   = item_ff;

   always_comb begin
      valid_in = accept || (valid_ff && !push);
      item_in  = accept ? decoded : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

FILE: sv/cau_queue.sv
// short item queue between the front end and the execution pipeline
`include "complex_arithmetic_unit_assert.svh"

module cau_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  cau_pkg::item_type           item_in,
   input  logic                        pop,
   output cau_pkg::item_type           item_out,
   output cau_pkg::queue_status_type   status
);
   import cau_pkg::*;

   item_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign status.full  = count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign item_out     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

   `CAU_ASSERT_NEVER(a_push_full, clock, reset, push && status.full, "push into full queue")
   `CAU_ASSERT_NEVER(a_pop_empty, clock, reset, pop && status.empty, "pop from empty queue")
   `CAU_ASSERT_IMPLY(a_count_ptr, clock, reset, status.empty, wr_ptr_ff == rd_ptr_ff, "pointers differ while empty")

endmodule

FILE: sv/cau_back.sv
// execution pipeline: multipliers, sums, divide and root stages, saturation
module cau_back (
   input  logic                        clock,
   input  logic                        reset,
   input  cau_pkg::queue_status_type   qstat,
   input  cau_pkg::item_type           qitem,
   output logic                        pop,
   output logic                        rsp_strobe,
   output logic signed [31:0]          rsp_res_re,
   output logic signed [31:0]          rsp_res_im,
   output logic                        rsp_is_equal,
   output logic                        rsp_div_zero,
   output logic                        rsp_saturated
);
   import cau_pkg::*;

   // stage 1: products and simple results
   logic                         s1_vld_ff;
   op_type                       s1_op_ff, s1_op_in;
   logic signed [PROD_WIDTH-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [PROD_WIDTH-1:0] p0_in, p1_in, p2_in, p3_in, p4_in, p5_in;
   data_type                     s1_re_ff, s1_re_in, s1_im_ff, s1_im_in;
   logic                         s1_eq_ff, s1_eq_in, s1_sat_ff, s1_sat_in;
   data_type                     x_re, x_im;
   res_type                      r_re, r_im;

   // stage 2: sums
   logic                         s2_vld_ff;
   op_type                       s2_op_ff;
   data_type                     s2_re_ff, s2_im_ff;
   logic                         s2_eq_ff, s2_sat_ff;
   logic signed [SUM_WIDTH-1:0]  sa_ff, sa_in, sb_ff, sb_in;
   logic [MAG_WIDTH-1:0]         den_ff, den_in;

   // stage 3 onward: iteration
   logic                         it_vld_ff [QUO_BITS+1];
   iter_type                     it_ff [QUO_BITS+1];
   iter_type                     it0_in;
   logic [MAG_WIDTH-1:0]         mag_a, mag_b;
   res_type                      m_re, m_im;

   // output
   iter_type                     fin;
   res_type                      f_re, f_im;
   logic                         strobe_ff;
   data_type                     res_re_ff, res_re_in, res_im_ff, res_im_in;
   logic                         eq_ff, eq_in, dz_ff, dz_in, sat_ff, sat_in;

   assign pop = !qstat.empty;

   always_comb begin
      s1_op_in = qitem.op;
      x_re  = (qitem.op == OP_MAG) ? qitem.a_re : qitem.b_re;
      x_im  = (qitem.op == OP_MAG) ? qitem.a_im : qitem.b_im;
      p0_in = qitem.a_re * qitem.b_re;
      p1_in = qitem.a_im * qitem.b_im;
      p2_in = qitem.a_re * qitem.b_im;
      p3_in = qitem.a_im * qitem.b_re;
      p4_in = x_re * x_re;
      p5_in = x_im * x_im;
      r_re  = '0;
      r_im  = '0;
      case (qitem.op)
         OP_ADD: begin
            r_re = sat_short((DATA_WIDTH + 1)'(qitem.a_re) + (DATA_WIDTH + 1)'(qitem.b_re));
            r_im = sat_short((DATA_WIDTH + 1)'(qitem.a_im) + (DATA_WIDTH + 1)'(qitem.b_im));
         end
         OP_SUB: begin
            r_re = sat_short((DATA_WIDTH + 1)'(qitem.a_re) - (DATA_WIDTH + 1)'(qitem.b_re));
            r_im = sat_short((DATA_WIDTH + 1)'(qitem.a_im) - (DATA_WIDTH + 1)'(qitem.b_im));
         end
         OP_NEG: begin
            r_re = sat_short(-(DATA_WIDTH + 1)'(qitem.a_re));
            r_im = sat_short(-(DATA_WIDTH + 1)'(qitem.a_im));
         end
         default: begin
            r_re = '0;
            r_im = '0;
         end
      endcase
      s1_re_in  = r_re.val;
      s1_im_in  = r_im.val;
      s1_sat_in = r_re.sat || r_im.sat;
      s1_eq_in  = (qitem.op == OP_EQU) && (qitem.a_re == qitem.b_re)
                  && (qitem.a_im == qitem.b_im);
   end

   always_ff @(posedge clock) begin
      s1_op_ff  <= s1_op_in;
      p0_ff     <= p0_in;
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      p3_ff     <= p3_in;
      p4_ff     <= p4_in;
      p5_ff     <= p5_in;
      s1_re_ff  <= s1_re_in;
      s1_im_ff  <= s1_im_in;
      s1_eq_ff  <= s1_eq_in;
      s1_sat_ff <= s1_sat_in;
   end

   always_comb begin
      if (s1_op_ff == OP_MUL) begin
         sa_in = SUM_WIDTH'(p0_ff) - SUM_WIDTH'(p1_ff);
         sb_in = SUM_WIDTH'(p2_ff) + SUM_WIDTH'(p3_ff);
      end else begin
         sa_in = SUM_WIDTH'(p0_ff) + SUM_WIDTH'(p1_ff);
         sb_in = SUM_WIDTH'(p3_ff) - SUM_WIDTH'(p2_ff);
      end
      den_in = MAG_WIDTH'(p4_ff) + MAG_WIDTH'(p5_ff);
   end

   always_ff @(posedge clock) begin
      s2_op_ff  <= s1_op_ff;
      s2_re_ff  <= s1_re_ff;
      s2_im_ff  <= s1_im_ff;
      s2_eq_ff  <= s1_eq_ff;
      s2_sat_ff <= s1_sat_ff;
      sa_ff     <= sa_in;
      sb_ff     <= sb_in;
      den_ff    <= den_in;
   end

   always_comb begin
      mag_a = sa_ff[SUM_WIDTH-1] ? MAG_WIDTH'(-sa_ff) : MAG_WIDTH'(sa_ff);
      mag_b = sb_ff[SUM_WIDTH-1] ? MAG_WIDTH'(-sb_ff) : MAG_WIDTH'(sb_ff);
      m_re  = sat_sm(sa_ff[SUM_WIDTH-1], mag_a >> FRAC_BITS);
      m_im  = sat_sm(sb_ff[SUM_WIDTH-1], mag_b >> FRAC_BITS);
      it0_in.done_op  = s2_op_ff;
      it0_in.done_re  = (s2_op_ff == OP_MUL) ? m_re.val : s2_re_ff;
      it0_in.done_im  = (s2_op_ff == OP_MUL) ? m_im.val : s2_im_ff;
      it0_in.done_sat = (s2_op_ff == OP_MUL) ? (m_re.sat || m_im.sat) : s2_sat_ff;
      it0_in.done_eq  = s2_eq_ff;
      it0_in.dz       = den_ff == '0;
      it0_in.neg_re   = sa_ff[SUM_WIDTH-1];
      it0_in.neg_im   = sb_ff[SUM_WIDTH-1];
      it0_in.ovf_re   = (mag_a >> HEAD_SHIFT) >= den_ff;
      it0_in.ovf_im   = (mag_b >> HEAD_SHIFT) >= den_ff;
      it0_in.rem_re   = REM_WIDTH'(mag_a >> HEAD_SHIFT);
      it0_in.rem_im   = REM_WIDTH'(mag_b >> HEAD_SHIFT);
      it0_in.nlo_re   = {mag_a[HEAD_SHIFT-1:0], {FRAC_BITS{1'b0}}};
      it0_in.nlo_im   = {mag_b[HEAD_SHIFT-1:0], {FRAC_BITS{1'b0}}};
      it0_in.q_re     = '0;
      it0_in.q_im     = '0;
      it0_in.den      = den_ff;
      it0_in.srem     = '0;
      it0_in.sroot    = '0;
      it0_in.sx       = SX_WIDTH'(den_ff);
   end

   always_ff @(posedge clock) begin
      it_ff[0] <= it0_in;
   end

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
      always_ff @(posedge clock) begin
         it_ff[k+1] <= iter_step(it_ff[k]);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            it_vld_ff[k+1] <= 1'b0;
         end else begin
            it_vld_ff[k+1] <= it_vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         it_vld_ff[0] <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         s1_vld_ff    <= pop;
         s2_vld_ff    <= s1_vld_ff;
         it_vld_ff[0] <= s2_vld_ff;
         strobe_ff    <= it_vld_ff[QUO_BITS];
      end
   end

   always_comb begin
      fin  = it_ff[QUO_BITS];
      f_re = sat_sm(fin.neg_re, fin.ovf_re ? {MAG_WIDTH{1'b1}} : MAG_WIDTH'(fin.q_re));
      f_im = sat_sm(fin.neg_im, fin.ovf_im ? {MAG_WIDTH{1'b1}} : MAG_WIDTH'(fin.q_im));
      res_re_in = fin.done_re;
      res_im_in = fin.done_im;
      eq_in     = fin.done_eq;
      dz_in     = 1'b0;
      sat_in    = fin.done_sat;
      case (fin.done_op)
         OP_DIV: begin
            if (fin.dz) begin
               res_re_in = '0;
               res_im_in = '0;
               dz_in     = 1'b1;
               sat_in    = 1'b0;
            end else begin
               res_re_in = f_re.val;
               res_im_in = f_im.val;
               sat_in    = f_re.sat || f_im.sat;
            end
         end
         OP_MAG: begin
            f_re      = sat_sm(1'b0, MAG_WIDTH'(fin.sroot));
            res_re_in = f_re.val;
            res_im_in = '0;
            sat_in    = f_re.sat;
         end
         default: begin
            dz_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_re_ff <= res_re_in;
      res_im_ff <= res_im_in;
      eq_ff     <= eq_in;
      dz_ff     <= dz_in;
      sat_ff    <= sat_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_res_re    = IN_WIDTH'(res_re_ff);
   assign rsp_res_im    = IN_WIDTH'(res_im_ff);
   assign rsp_is_equal  = eq_ff;
   assign rsp_div_zero  = dz_ff;
   assign rsp_saturated = sat_ff;

endmodule

FILE: sv/complex_arithmetic_unit.sv
// top level of the complex arithmetic unit
//
//   port group   direction   transfer when
//   req_*        in          start high and busy low at a rising edge
//   rsp_*        out         rsp_strobe high, one cycle per result
//
// each request yields one result; the 33 quotient and root stages set the latency
// one request per cycle is taken while busy is low
// reset is synchronous and empties the queue and every pipeline stage
// busy is high during reset and while an item waits at the front on a full queue
// results leave without any hold-off from the receiver
module complex_arithmetic_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic signed [31:0] req_a_re,
   input  logic signed [31:0] req_a_im,
   input  logic signed [31:0] req_b_re,
   input  logic signed [31:0] req_b_im,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_res_re,
   output logic signed [31:0] rsp_res_im,
   output logic               rsp_is_equal,
   output logic               rsp_div_zero,
   output logic               rsp_saturated
);
   import cau_pkg::*;

   item_type         front_item;
   item_type         queue_item;
   logic             push;
   logic             pop;
   queue_status_type qstat;

   cau_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_action (req_action),
      .req_a_re   (req_a_re),
      .req_a_im   (req_a_im),
      .req_b_re   (req_b_re),
      .req_b_im   (req_b_im),
      .qstat      (qstat),
      .push       (push),
      .item       (front_item)
   );

   cau_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .item_in  (front_item),
      .pop      (pop),
      .item_out (queue_item),
      .status   (qstat)
   );

   cau_back u_back (
      .clock         (clock),
      .reset         (reset),
      .qstat         (qstat),
      .qitem         (queue_item),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_res_re    (rsp_res_re),
      .rsp_res_im    (rsp_res_im),
      .rsp_is_equal  (rsp_is_equal),
      .rsp_div_zero  (rsp_div_zero),
      .rsp_saturated (rsp_saturated)
   );

endmodule

FILE: test/complex_arithmetic_unit_test.sv
// self-checking testbench of the complex arithmetic unit: directed table then random operations
`timescale 1ns / 100ps

module complex_arithmetic_unit_test;
   import cau_pkg::*;

   localparam int LATENCY = 38;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1025;
   localparam int CALM_ITEMS = 150;
   localparam logic signed [31:0] MAX_Q = 32'sh7fffffff;
   localparam logic signed [31:0] MIN_Q = 32'sh80000000;
   localparam logic signed [31:0] ONE_Q = 32'sh00010000;

   typedef struct {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               eq;
      logic               dz;
      logic               sat;
   } result_type;

   typedef struct {
      op_type             op;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
      logic               fixed;
      result_type         want;
   } row_type;

   typedef struct {
      logic        neg;
      logic [63:0] mag;
   } signmag_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_action = '0;
   logic signed [31:0] req_a_re = '0;
   logic signed [31:0] req_a_im = '0;
   logic signed [31:0] req_b_re = '0;
   logic signed [31:0] req_b_im = '0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_res_re;
   logic signed [31:0] rsp_res_im;
   logic               rsp_is_equal;
   logic               rsp_div_zero;
   logic               rsp_saturated;

   result_type pending_results[$];
   row_type    directed_rows[$];
   int         failures = 0;
   int         quiet_cycles = 0;

   complex_arithmetic_unit u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_a_re(req_a_re),
      .req_a_im(req_a_im),
      .req_b_re(req_b_re),
      .req_b_im(req_b_im),
      .rsp_strobe(rsp_strobe),
      .rsp_res_re(rsp_res_re),
      .rsp_res_im(rsp_res_im),
      .rsp_is_equal(rsp_is_equal),
      .rsp_div_zero(rsp_div_zero),
      .rsp_saturated(rsp_saturated)
   );

   always #1 clock = ~clock;

   function automatic signmag_type to_signmag(input longint v);
      signmag_type r;
      r.neg = v < 0;
      r.mag = r.neg ? 64'(-v) : 64'(v);
      return r;
   endfunction

   function automatic signmag_type signmag_mul(input longint a, input longint b);
      signmag_type x, y, r;
      x = to_signmag(a);
      y = to_signmag(b);
      r.mag = x.mag * y.mag;
      r.neg = (x.neg != y.neg) && r.mag != 0;
      return r;
   endfunction

   function automatic signmag_type signmag_negate(input signmag_type x);
      signmag_type r;
      r.mag = x.mag;
      r.neg = !x.neg && x.mag != 0;
      return r;
   endfunction

   function automatic signmag_type signmag_sum(input signmag_type x, input signmag_type y);
      signmag_type r;
      if (x.neg == y.neg) begin
         r.mag = x.mag + y.mag;
         r.neg = x.neg;
      end else if (x.mag >= y.mag) begin
         r.mag = x.mag - y.mag;
         r.neg = x.neg;
      end else begin
         r.mag = y.mag - x.mag;
         r.neg = y.neg;
      end
      if (r.mag == 0) r.neg = 1'b0;
      return r;
   endfunction

   function automatic logic signed [31:0] clip_q(input signmag_type x, inout logic sat);
      logic [63:0] maxpos;
      maxpos = 64'h7fffffff;
      if (!x.neg) begin
         if (x.mag > maxpos) begin
            sat = 1'b1;
            return MAX_Q;
         end
         return x.mag[31:0];
      end
      if (x.mag > maxpos + 1) begin
         sat = 1'b1;
         return MIN_Q;
      end
      return -x.mag[31:0];
   endfunction

   function automatic logic [63:0] scaled_quotient(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q, r, cap;
      cap = 64'd1 << 40;
      q = n / d;
      r = n % d;
      if (q > cap) q = cap;
      for (int i = 0; i < FRAC_BITS; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 64'd1;
         end
         if (q > cap) q = cap;
      end
      return q;
   endfunction

   function automatic logic [63:0] floor_root(input logic [63:0] x);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x = x - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic result_type complex_result(input op_type op,
         input logic signed [31:0] a_re, input logic signed [31:0] a_im,
         input logic signed [31:0] b_re, input logic signed [31:0] b_im);
      result_type  r;
      longint      ar, ai, br, bi;
      signmag_type pr, pi;
      logic [63:0] den;
      ar = a_re;
      ai = a_im;
      br = b_re;
      bi = b_im;
      r = '{re: 0, im: 0, eq: 0, dz: 0, sat: 0};
      case (op)
         OP_ADD: begin
            r.re = clip_q(to_signmag(ar + br), r.sat);
            r.im = clip_q(to_signmag(ai + bi), r.sat);
         end
         OP_SUB: begin
            r.re = clip_q(to_signmag(ar - br), r.sat);
            r.im = clip_q(to_signmag(ai - bi), r.sat);
         end
         OP_MUL: begin
            pr = signmag_sum(signmag_mul(ar, br), signmag_negate(signmag_mul(ai, bi)));
            pi = signmag_sum(signmag_mul(ar, bi), signmag_mul(ai, br));
            pr.mag = pr.mag >> FRAC_BITS;
            pi.mag = pi.mag >> FRAC_BITS;
            r.re = clip_q(pr, r.sat);
            r.im = clip_q(pi, r.sat);
         end
         OP_DIV: begin
            den = signmag_mul(br, br).mag + signmag_mul(bi, bi).mag;
            if (den == 0) begin
               r.dz = 1'b1;
            end else begin
               pr = signmag_sum(signmag_mul(ar, br), signmag_mul(ai, bi));
               pi = signmag_sum(signmag_mul(ai, br), signmag_negate(signmag_mul(ar, bi)));
               pr.mag = scaled_quotient(pr.mag, den);
               pi.mag = scaled_quotient(pi.mag, den);
               r.re = clip_q(pr, r.sat);
               r.im = clip_q(pi, r.sat);
            end
         end
         OP_NEG: begin
            r.re = clip_q(to_signmag(-ar), r.sat);
            r.im = clip_q(to_signmag(-ai), r.sat);
         end
         OP_EQU: r.eq = (ar == br) && (ai == bi);
         OP_MAG: begin
            pr.neg = 1'b0;
            pr.mag = floor_root(signmag_mul(ar, ar).mag + signmag_mul(ai, ai).mag);
            r.re = clip_q(pr, r.sat);
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void add_row(input op_type op,
         input logic signed [31:0] a_re, input logic signed [31:0] a_im,
         input logic signed [31:0] b_re, input logic signed [31:0] b_im,
         input logic fixed = 1'b0, input logic signed [31:0] w_re = 0,
         input logic signed [31:0] w_im = 0, input logic w_eq = 0,
         input logic w_dz = 0, input logic w_sat = 0);
      row_type row;
      row.op = op;
      row.a_re = a_re;
      row.a_im = a_im;
      row.b_re = b_re;
      row.b_im = b_im;
      row.fixed = fixed;
      row.want = '{re: w_re, im: w_im, eq: w_eq, dz: w_dz, sat: w_sat};
      directed_rows.push_back(row);
   endfunction

   function automatic logic signed [31:0] random_operand();
      case ($urandom_range(0, 9))
         0: return MAX_Q;
         1: return MIN_Q;
         2: return 0;
         3, 4, 5: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
         6, 7: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
         default: return $urandom;
      endcase
   endfunction

   task automatic transfer_request(input op_type op,
         input logic signed [31:0] a_re, input logic signed [31:0] a_im,
         input logic signed [31:0] b_re, input logic signed [31:0] b_im,
         input result_type want);
      start <= 1'b1;
      req_action <= op;
      req_a_re <= a_re;
      req_a_im <= a_im;
      req_b_re <= b_re;
      req_b_im <= b_im;
      do @(posedge clock); while (busy);
      pending_results.push_back(want);
   endtask

   task automatic idle_burst(input bit allow);
      int n;
      if (allow && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 8);
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[complex_arithmetic_unit] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("result with no request outstanding");
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_res_re !== want.re) begin
               $error("res_re expected %h actual %h", want.re, rsp_res_re);
               failures++;
            end
            if (rsp_res_im !== want.im) begin
               $error("res_im expected %h actual %h", want.im, rsp_res_im);
               failures++;
            end
            if (rsp_is_equal !== want.eq) begin
               $error("is_equal expected %b actual %b", want.eq, rsp_is_equal);
               failures++;
            end
            if (rsp_div_zero !== want.dz) begin
               $error("div_zero expected %b actual %b", want.dz, rsp_div_zero);
               failures++;
            end
            if (rsp_saturated !== want.sat) begin
               $error("saturated expected %b actual %b", want.sat, rsp_saturated);
               failures++;
            end
         end
      end
   end

   initial begin
      op_type             op;
      logic signed [31:0] a_re, a_im, b_re, b_im;
      int                 waited;

      add_row(OP_ADD, 0, 0, 0, 0, 1);
      add_row(OP_ADD, MAX_Q, 0, ONE_Q, 0, 1, MAX_Q, 0, 0, 0, 1);
      add_row(OP_SUB, MIN_Q, MAX_Q, ONE_Q, MIN_Q, 1, MIN_Q, MAX_Q, 0, 0, 1);
      add_row(OP_SUB, MAX_Q, MIN_Q, MAX_Q, MIN_Q, 1);
      add_row(OP_NEG, MIN_Q, MIN_Q, 0, 0, 1, MAX_Q, MAX_Q, 0, 0, 1);
      add_row(OP_NEG, MAX_Q, ONE_Q, 0, 0, 1, -MAX_Q, -ONE_Q);
      add_row(OP_DIV, ONE_Q, ONE_Q, 0, 0, 1, 0, 0, 0, 1, 0);
      add_row(OP_DIV, MAX_Q, MIN_Q, 0, 0, 1, 0, 0, 0, 1, 0);
      add_row(OP_EQU, ONE_Q, MIN_Q, ONE_Q, MIN_Q, 1, 0, 0, 1);
      add_row(OP_EQU, ONE_Q, MIN_Q, ONE_Q, MAX_Q, 1);
      add_row(OP_NONE, MAX_Q, MIN_Q, ONE_Q, MAX_Q, 1);
      add_row(OP_MAG, 3 * ONE_Q, -4 * ONE_Q, 0, 0, 1, 5 * ONE_Q);
      add_row(OP_MAG, MIN_Q, MIN_Q, 0, 0, 1, MAX_Q, 0, 0, 0, 1);
      add_row(OP_MAG, MAX_Q, 0, 0, 0);
      add_row(OP_MUL, MAX_Q, MAX_Q, MAX_Q, MAX_Q);
      add_row(OP_MUL, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
      add_row(OP_MUL, MIN_Q, 0, MAX_Q, 0);
      add_row(OP_MUL, 3 * ONE_Q, -2 * ONE_Q, ONE_Q / 2, 7 * ONE_Q);
      add_row(OP_MUL, -1, 1, 1, 1);
      add_row(OP_DIV, 5 * ONE_Q, -3 * ONE_Q, 2 * ONE_Q, ONE_Q);
      add_row(OP_DIV, MAX_Q, MAX_Q, 1, 0);
      add_row(OP_DIV, MIN_Q, 1, MIN_Q, MIN_Q);
      add_row(OP_DIV, ONE_Q, 0, 0, -3);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         transfer_request(directed_rows[i].op, directed_rows[i].a_re, directed_rows[i].a_im,
                          directed_rows[i].b_re, directed_rows[i].b_im,
                          directed_rows[i].fixed ? directed_rows[i].want :
                          complex_result(directed_rows[i].op, directed_rows[i].a_re,
                                         directed_rows[i].a_im, directed_rows[i].b_re,
                                         directed_rows[i].b_im));
         idle_burst(1'b1);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         op = op_type'($urandom_range(0, 7));
         a_re = random_operand();
         a_im = random_operand();
         b_re = random_operand();
         b_im = random_operand();
         if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
            b_re = 0;
            b_im = 0;
         end
         if (op == OP_EQU && $urandom_range(0, 1) == 0) begin
            b_re = a_re;
            if ($urandom_range(0, 2) != 0) b_im = a_im;
         end
         transfer_request(op, a_re, a_im, b_re, b_im,
                          complex_result(op, a_re, a_im, b_re, b_im));
         if (n == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end else begin
            idle_burst(n < RANDOM_ITEMS - CALM_ITEMS);
         end
      end
      start <= 1'b0;

      waited = 0;
      while (pending_results.size() != 0 && waited < 20 * LATENCY) begin
         @(posedge clock);
         waited++;
      end
      repeat (2 * LATENCY) @(posedge clock);
      if (failures == 0 && pending_results.size() == 0) begin
         $display("[complex_arithmetic_unit] OK");
      end else begin
         $display("[complex_arithmetic_unit] ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_queue.sv
sv/cau_back.sv
sv/complex_arithmetic_unit.sv
test/complex_arithmetic_unit_test.sv
